### rtl/imq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imq_pkg: shared types and constants of the indexed multi-queue bank
// Status codes, opcodes, queue-limit reset value and queue selector width.
// ----------------------------------------------------------------------------
package imq_pkg;

    // operation carried by an input transaction
    typedef enum logic [0:0] {
        OP_ENQUEUE = 1'b0,
        OP_DEQUEUE = 1'b1
    } t_opcode;

    // status reported with every result transaction
    typedef enum logic [2:0] {
        ST_DEQUEUED  = 3'd0,
        ST_ENQUEUED  = 3'd1,
        ST_BAD_QUEUE = 3'd2,
        ST_EMPTY     = 3'd3,
        ST_FULL      = 3'd4
    } t_status;

    // queue-limit register
    localparam int unsigned QIU_BITS = 4;
    localparam logic [QIU_BITS-1:0] QIU_RESET = 4'd8;

    // queue selector width
    localparam int unsigned QNUM_BITS = 8;

endpackage

### rtl/indexed_multi_queue_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_multi_queue_top: bank of independent FIFO queues
// Input channel (i_valid / o_stall): opcode, one-based queue number and a
// customer id. Enqueue appends the id to the named queue, dequeue returns
// its oldest id. Every input transaction yields one result transaction
// (o_valid / i_stall) with a status code and the leaving id (zero unless a
// dequeue succeeded). Queue numbers outside 1..queues_in_use (capped at NUM_QUEUES) are rejected.
// Path: a rejected queue number goes from accept straight to the final state,
// an enqueue or a failed dequeue passes the pointer-read state, a successful
// dequeue the pointer-read and entry-read states; o_valid is registered.
// One transaction is in work at a time; the pointer-memory read, update and
// the dependent entry-memory read run in sequence per item.
// o_stall is high while an item is in work. The result register lets the
// next item be accepted while a finished result still waits; if i_stall
// holds the result, the following item waits in its final state.
// Reset clears all queues (pointer valid bits) and sets queues_in_use to 8.
// i_cfg_we writes queues_in_use; write it only while the block is idle.
// ----------------------------------------------------------------------------
module indexed_multi_queue_top #(
    parameter int unsigned NUM_QUEUES  = 8,
    parameter int unsigned QUEUE_DEPTH = 16,
    parameter int unsigned ID_BITS     = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          i_cfg_we,
    input  logic [imq_pkg::QIU_BITS-1:0]  i_cfg_wdata,
    // input channel
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_opcode,
    input  logic [imq_pkg::QNUM_BITS-1:0] i_queue_number,
    input  logic [ID_BITS-1:0]            i_customer_id,
    // result channel
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [2:0]                    o_status,
    output logic [ID_BITS-1:0]            o_leaving_id
);

    localparam int unsigned QW     = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int unsigned PW     = $clog2(QUEUE_DEPTH);
    localparam int unsigned CW     = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned RECW   = 2 * PW + CW;
    localparam int unsigned AW     = QW + PW;
    localparam int unsigned EDEPTH = NUM_QUEUES << PW;
    localparam int unsigned QNW    = imq_pkg::QNUM_BITS;

    localparam logic [PW-1:0]  PTR_LAST = PW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0]  CNT_FULL = CW'(QUEUE_DEPTH);
    localparam logic [QNW-1:0] QN_MAX   = QNW'(NUM_QUEUES);

    typedef enum logic [1:0] {
        S_IDLE,
        S_PTR,
        S_ENT,
        S_FIN
    } t_state;

    // ring pointer advance, wraps at QUEUE_DEPTH
    function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
        logic [PW-1:0] r;
        r = (p == PTR_LAST) ? '0 : p + PW'(1);
        return r;
    endfunction

    t_state                           r_state;
    imq_pkg::t_opcode                 r_op;
    logic [QW-1:0]                    r_qidx;
    logic [ID_BITS-1:0]               r_id;
    imq_pkg::t_status                 r_status;
    logic [ID_BITS-1:0]               r_leave;
    logic [imq_pkg::QIU_BITS-1:0]     r_qiu;
    logic                             r_out_valid;
    imq_pkg::t_status                 r_out_status;
    logic [ID_BITS-1:0]               r_out_id;

    logic                             in_acc;
    logic                             out_take;
    logic                             out_free;
    logic [QNW-1:0]                   lim;
    logic                             qn_ok;
    logic [QW-1:0]                    q_in;

    logic [RECW-1:0]                  ptr_rdata;
    logic [RECW-1:0]                  ptr_wdata;
    logic                             ptr_we;
    logic [PW-1:0]                    cur_head;
    logic [PW-1:0]                    cur_tail;
    logic [CW-1:0]                    cur_cnt;
    logic                             q_full;
    logic                             q_empty;

    logic                             ent_we;
    logic                             ent_re;
    logic [AW-1:0]                    ent_waddr;
    logic [AW-1:0]                    ent_raddr;
    logic [ID_BITS-1:0]               ent_rdata;

    // handshakes
    assign in_acc   = i_valid && (r_state == S_IDLE);
    assign o_stall  = (r_state != S_IDLE);
    assign out_take = r_out_valid && !i_stall;
    assign out_free = !r_out_valid || !i_stall;

    // queue number check against the saturated limit
    always_comb begin
        lim   = (r_qiu > QN_MAX) ? QN_MAX : QNW'(r_qiu);
        qn_ok = (i_queue_number != '0) && (i_queue_number <= lim);
        q_in  = QW'(i_queue_number - QNW'(1));
    end

    // pointer record fields
    assign cur_head = ptr_rdata[RECW-1 -: PW];
    assign cur_tail = ptr_rdata[CW +: PW];
    assign cur_cnt  = ptr_rdata[CW-1:0];
    assign q_full   = (cur_cnt == CNT_FULL);
    assign q_empty  = (cur_cnt == '0);

    // pointer and entry updates in the pointer-read state
    always_comb begin
        ptr_we    = 1'b0;
        ptr_wdata = ptr_rdata;
        ent_we    = 1'b0;
        ent_re    = 1'b0;
        ent_waddr = {r_qidx, cur_tail};
        ent_raddr = {r_qidx, cur_head};
        if (r_state == S_PTR) begin
            if (r_op == imq_pkg::OP_ENQUEUE) begin
                if (!q_full) begin
                    ptr_we    = 1'b1;
                    ent_we    = 1'b1;
                    ptr_wdata = {cur_head, ring_next(cur_tail), cur_cnt + CW'(1)};
                end
            end else begin
                if (!q_empty) begin
                    ptr_we    = 1'b1;
                    ent_re    = 1'b1;
                    ptr_wdata = {ring_next(cur_head), cur_tail, cur_cnt - CW'(1)};
                end
            end
        end
    end

    // sequencer with result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_qiu       <= imq_pkg::QIU_RESET;
        end else begin
            if (i_cfg_we) begin
                r_qiu <= i_cfg_wdata;
            end
            // result valid: load from the final state, clear when taken
            if ((r_state == S_FIN) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_op     <= imq_pkg::t_opcode'(i_opcode);
                        r_qidx   <= q_in;
                        r_id     <= i_customer_id;
                        r_leave  <= '0;
                        r_status <= imq_pkg::ST_BAD_QUEUE;
                        r_state  <= qn_ok ? S_PTR : S_FIN;
                    end
                end
                S_PTR: begin
                    r_state <= S_FIN;
                    if (r_op == imq_pkg::OP_ENQUEUE) begin
                        r_status <= q_full ? imq_pkg::ST_FULL : imq_pkg::ST_ENQUEUED;
                    end else if (q_empty) begin
                        r_status <= imq_pkg::ST_EMPTY;
                    end else begin
                        r_status <= imq_pkg::ST_DEQUEUED;
                        r_state  <= S_ENT;
                    end
                end
                S_ENT: begin
                    r_leave <= ent_rdata;
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (out_free) begin
                        r_out_status <= r_status;
                        r_out_id     <= r_leave;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid      = r_out_valid;
    assign o_status     = r_out_status;
    assign o_leaving_id = r_out_id;

    // pointer memory: head, tail and count per queue
    imq_ptr_mem #(
        .NUM_QUEUES (NUM_QUEUES),
        .QW         (QW),
        .RECW       (RECW)
    ) u_ptr_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_acc),
        .i_rd_addr (q_in),
        .o_rd_data (ptr_rdata),
        .i_wr_en   (ptr_we),
        .i_wr_addr (r_qidx),
        .i_wr_data (ptr_wdata)
    );

    // identifier memory, addressed by {queue, slot}
    imq_entry_mem #(
        .DEPTH (EDEPTH),
        .AW    (AW),
        .DW    (ID_BITS)
    ) u_entry_mem (
        .i_clk     (i_clk),
        .i_rd_en   (ent_re),
        .i_rd_addr (ent_raddr),
        .o_rd_data (ent_rdata),
        .i_wr_en   (ent_we),
        .i_wr_addr (ent_waddr),
        .i_wr_data (r_id)
    );

    // a new result only comes out of the final state
    a_out_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_FIN))
        else $error("result loaded outside final state");

    // only a successful dequeue returns a nonzero id
    a_leave_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != imq_pkg::ST_DEQUEUED)) |-> (o_leaving_id == '0))
        else $error("nonzero leaving id without dequeue");

    // an accepted transaction goes to pointer read or straight to the result
    a_acc_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> ((r_state == S_PTR) || (r_state == S_FIN)))
        else $error("bad state after accept");

    // entry read state follows a pointer update of a dequeue
    a_ent_after_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ENT) |-> $past(ptr_we && (r_op == imq_pkg::OP_DEQUEUE)))
        else $error("entry read without pointer update");

    // memories are never written while idle
    a_no_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!ptr_we && !ent_we))
        else $error("memory write while idle");

endmodule

### rtl/imq_ptr_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imq_ptr_mem: per-queue pointer memory
// One record per queue ({head, tail, count}), registered read.
// A per-entry valid bit makes an unwritten record read as all zero.
// ----------------------------------------------------------------------------
module imq_ptr_mem #(
    parameter int unsigned NUM_QUEUES = 8,
    parameter int unsigned QW         = 3,
    parameter int unsigned RECW       = 13
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_rd_en,
    input  logic [QW-1:0]   i_rd_addr,
    output logic [RECW-1:0] o_rd_data,
    input  logic            i_wr_en,
    input  logic [QW-1:0]   i_wr_addr,
    input  logic [RECW-1:0] i_wr_data
);

    logic [RECW-1:0]       r_mem [NUM_QUEUES];
    logic [NUM_QUEUES-1:0] r_vld;
    logic [RECW-1:0]       r_rd_data;
    logic                  r_rd_vld;

    // storage array and read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // valid bits, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_addr];
            end
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
        end
    end

    // unwritten record reads as the reset value
    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

### rtl/imq_entry_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imq_entry_mem: identifier storage for all queues
// Simple dual-port memory, one write and one registered read per cycle.
// Contents are undefined until written.
// ----------------------------------------------------------------------------
module imq_entry_mem #(
    parameter int unsigned DEPTH = 128,
    parameter int unsigned AW    = 7,
    parameter int unsigned DW    = 32
) (
    input  logic          i_clk,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [DW-1:0] o_rd_data,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd_data;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### dv/indexed_multi_queue_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_multi_queue_top_test: self-checking bench for the multi-queue bank
// Drives enqueue/dequeue transactions through the valid/stall input channel,
// predicts every status and leaving id with a behavioral queue bank of its
// own and compares each result transaction in order. Covers bad queue
// numbers, empty and full queues, several queue limits (0, 1, 3, 8, 15),
// random idle gaps on both sides and a long receiver hold-off.
// ----------------------------------------------------------------------------
module indexed_multi_queue_top_test;

    localparam int unsigned NUM_Q       = 8;
    localparam int unsigned DEPTH       = 16;
    localparam int unsigned ID_W        = 32;
    localparam int unsigned SETTLE_CYC  = 8;
    localparam int unsigned CYCLE_LIMIT = 200000;

    typedef struct packed {
        imq_pkg::t_status status;
        logic [ID_W-1:0]  leaving_id;
    } t_result;

    // DUT ports
    logic                           i_clk          = 1'b0;
    logic                           i_rst_n        = 1'b0;
    logic                           i_cfg_we       = 1'b0;
    logic [imq_pkg::QIU_BITS-1:0]   i_cfg_wdata    = '0;
    logic                           i_valid        = 1'b0;
    logic                           o_stall;
    logic                           i_opcode       = 1'b0;
    logic [imq_pkg::QNUM_BITS-1:0]  i_queue_number = '0;
    logic [ID_W-1:0]                i_customer_id  = '0;
    logic                           o_valid;
    logic                           i_stall        = 1'b0;
    logic [2:0]                     o_status;
    logic [ID_W-1:0]                o_leaving_id;

    // behavioral queue bank
    logic [imq_pkg::QIU_BITS-1:0]   bank_limit = imq_pkg::QIU_RESET;
    logic [ID_W-1:0]                bank_store [NUM_Q][DEPTH];
    logic [3:0]                     bank_head  [NUM_Q];
    logic [3:0]                     bank_tail  [NUM_Q];
    logic [4:0]                     bank_fill  [NUM_Q];

    // results still owed by the DUT, oldest first
    t_result               owed_results[$];

    // run control and bookkeeping
    bit                    tx_idle     = 1'b1;
    bit                    rx_idle     = 1'b1;
    int                    rx_wait     = 0;
    int                    hold_left   = 0;
    int unsigned           cycle_count = 0;
    int unsigned           error_count = 0;
    int unsigned           sent_count  = 0;
    int unsigned           status_seen [5];

    indexed_multi_queue_top #(
        .NUM_QUEUES  (NUM_Q),
        .QUEUE_DEPTH (DEPTH),
        .ID_BITS     (ID_W)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_opcode       (i_opcode),
        .i_queue_number (i_queue_number),
        .i_customer_id  (i_customer_id),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_status       (o_status),
        .o_leaving_id   (o_leaving_id)
    );

    // clock
    always #2 i_clk = ~i_clk;

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d results outstanding",
                     $time, cycle_count, owed_results.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Queue bank update for one accepted transaction; returns the result owed.
    function automatic t_result bank_apply(input imq_pkg::t_opcode op,
                                           input logic [7:0] qn,
                                           input logic [ID_W-1:0] cid);
        t_result     res;
        int unsigned lim;
        int unsigned q;
        lim = (bank_limit > NUM_Q) ? NUM_Q : bank_limit;
        res.status     = imq_pkg::ST_BAD_QUEUE;
        res.leaving_id = '0;
        if (qn >= 1 && qn <= lim) begin
            q = qn - 1;
            if (op == imq_pkg::OP_ENQUEUE) begin
                if (bank_fill[q] == DEPTH) begin
                    res.status = imq_pkg::ST_FULL;
                end else begin
                    bank_store[q][bank_tail[q]] = cid;
                    bank_tail[q] = bank_tail[q] + 1'b1;   // wraps at depth 16
                    bank_fill[q] = bank_fill[q] + 1'b1;
                    res.status   = imq_pkg::ST_ENQUEUED;
                end
            end else begin
                if (bank_fill[q] == 0) begin
                    res.status = imq_pkg::ST_EMPTY;
                end else begin
                    res.leaving_id = bank_store[q][bank_head[q]];
                    bank_head[q]   = bank_head[q] + 1'b1;
                    bank_fill[q]   = bank_fill[q] - 1'b1;
                    res.status     = imq_pkg::ST_DEQUEUED;
                end
            end
        end
        return res;
    endfunction

    // Result checker: compare each accepted result with the oldest prediction.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (owed_results.size() == 0) begin
                $display("%0t: unexpected result, status %0d leaving_id %h",
                         $time, o_status, o_leaving_id);
                error_count++;
            end else begin
                want = owed_results.pop_front();
                if (o_status !== want.status) begin
                    $display("%0t: status mismatch, expected %0d, actual %0d",
                             $time, want.status, o_status);
                    error_count++;
                end
                if (o_leaving_id !== want.leaving_id) begin
                    $display("%0t: leaving_id mismatch, expected %h, actual %h",
                             $time, want.leaving_id, o_leaving_id);
                    error_count++;
                end
            end
            if (o_status < 5)
                status_seen[o_status]++;
            rx_wait = rx_idle ? $urandom_range(0, 16) : 0;
        end
    end

    // Receiver stall: long hold-off takes priority over the per-result wait.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left--;
        end else if (rx_wait > 0) begin
            i_stall <= 1'b1;
            rx_wait--;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Offer one transaction; called and returns at a falling edge.
    task automatic send_request(input imq_pkg::t_opcode op, input logic [7:0] qn,
                                input logic [ID_W-1:0] cid);
        int gap;
        gap = tx_idle ? $urandom_range(0, 16) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid        <= 1'b1;
        i_opcode       <= op;
        i_queue_number <= qn;
        i_customer_id  <= cid;
        do @(posedge i_clk); while (o_stall);
        owed_results.push_back(bank_apply(op, qn, cid));
        sent_count++;
        @(negedge i_clk);
    endtask

    // Stop sending and wait until every owed result has come back.
    task automatic wait_for_idle();
        i_valid <= 1'b0;
        while (owed_results.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYC) @(negedge i_clk);
    endtask

    // Register write, only while the block is idle.
    task automatic write_limit(input logic [imq_pkg::QIU_BITS-1:0] value);
        wait_for_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        bank_limit   = value;
        @(negedge i_clk);
    endtask

    function automatic logic [ID_W-1:0] pick_id();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // Mostly legal queue numbers, with zero, just past the limit and noise.
    function automatic logic [7:0] pick_queue();
        int unsigned lim;
        lim = (bank_limit > NUM_Q) ? NUM_Q : bank_limit;
        case ($urandom_range(0, 19))
            0:       return 8'd0;
            1:       return 8'($urandom_range(0, 255));
            2:       return 8'(lim + 1);
            default: return (lim == 0) ? 8'($urandom_range(1, NUM_Q))
                                       : 8'($urandom_range(1, lim));
        endcase
    endfunction

    // Empty queue, bad queue numbers and identifier extremes.
    task automatic test_basic_ops();
        send_request(imq_pkg::OP_DEQUEUE, 8'd1,   32'h1234_5678);
        send_request(imq_pkg::OP_ENQUEUE, 8'd0,   32'hDEAD_BEEF);
        send_request(imq_pkg::OP_DEQUEUE, 8'd255, '0);
        send_request(imq_pkg::OP_ENQUEUE, 8'd9,   32'h0BAD_0009);
        send_request(imq_pkg::OP_ENQUEUE, 8'd1,   '0);
        send_request(imq_pkg::OP_ENQUEUE, 8'd1,   '1);
        send_request(imq_pkg::OP_DEQUEUE, 8'd1,   32'h5555_AAAA);
        send_request(imq_pkg::OP_DEQUEUE, 8'd1,   '0);
    endtask

    // Fill the last queue to depth and overflow it once.
    task automatic test_full_queue();
        for (int n = 0; n <= DEPTH; n++)
            send_request(imq_pkg::OP_ENQUEUE, 8'(NUM_Q), 32'hF000_0000 | 32'(n));
    endtask

    // Register extremes: saturation above NUM_Q, zero and one.
    task automatic test_limit_extremes();
        write_limit(4'd15);
        send_request(imq_pkg::OP_DEQUEUE, 8'd8,  '0);
        send_request(imq_pkg::OP_ENQUEUE, 8'd9,  32'hAAAA_5555);
        send_request(imq_pkg::OP_DEQUEUE, 8'd15, '0);
        write_limit(4'd0);
        send_request(imq_pkg::OP_ENQUEUE, 8'd1,  32'h0000_0001);
        send_request(imq_pkg::OP_DEQUEUE, 8'd1,  '0);
        write_limit(4'd1);
        send_request(imq_pkg::OP_ENQUEUE, 8'd1,  32'h8000_0000);
        send_request(imq_pkg::OP_ENQUEUE, 8'd2,  32'h7FFF_FFFF);
    endtask

    // Random traffic with a given share of enqueues.
    task automatic test_random_traffic(input int count, input int enq_pct);
        imq_pkg::t_opcode op;
        for (int n = 0; n < count; n++) begin
            op = ($urandom_range(0, 99) < enq_pct) ? imq_pkg::OP_ENQUEUE
                                                   : imq_pkg::OP_DEQUEUE;
            send_request(op, pick_queue(), pick_id());
        end
    endtask

    // Receiver holds off while the sender keeps offering back to back.
    task automatic test_backpressure();
        bit saved_idle;
        saved_idle = tx_idle;
        tx_idle    = 1'b0;
        @(posedge i_clk);
        hold_left = 80;
        @(negedge i_clk);
        test_random_traffic(12, 50);
        tx_idle = saved_idle;
        wait_for_idle();
    endtask

    // Test sequence
    initial begin
        foreach (bank_fill[q]) begin
            bank_head[q] = '0;
            bank_tail[q] = '0;
            bank_fill[q] = '0;
        end
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_basic_ops();
        test_full_queue();
        wait_for_idle();
        test_random_traffic(70, 65);
        test_backpressure();
        test_random_traffic(60, 35);
        test_limit_extremes();
        test_random_traffic(50, 70);
        test_random_traffic(30, 30);
        write_limit(4'd15);
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        test_random_traffic(60, 55);
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        write_limit(4'd0);
        test_random_traffic(15, 50);
        write_limit(4'd3);
        test_random_traffic(60, 50);
        test_backpressure();
        write_limit(4'd8);
        test_random_traffic(20, 40);
        wait_for_idle();

        $display("Sent %0d transactions under queue limits 8, 15, 1, 0 and 3.", sent_count);
        $display("Statuses seen: %0d dequeued, %0d enqueued, %0d bad, %0d empty, %0d full.",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4]);
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches", error_count);
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

### indexed_multi_queue_top.f
rtl/imq_pkg.sv
rtl/imq_ptr_mem.sv
rtl/imq_entry_mem.sv
rtl/indexed_multi_queue_top.sv
dv/indexed_multi_queue_top_test.sv
